[rtl/core/escape_count_cosine_palette_macros.svh]
// Assertion helpers used by the top block of the palette.
`ifndef ESCAPE_COUNT_COSINE_PALETTE_MACROS_SVH
`define ESCAPE_COUNT_COSINE_PALETTE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ECP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("palette assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ECP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("palette assertion failed");

`endif

[rtl/core/ecp_pkg.sv]
`timescale 1ns / 1ps

package ecp_pkg;

  // floor(2^32 / pi) and pi in Q30.
  localparam logic [30:0] ECP_INV_PI_Q32 = 31'h517CC1B7;
  localparam logic [31:0] ECP_PI_Q30     = 32'hC90FDAA2;

  // 200 rad and 100 rad as 16-bit fractions of a turn.
  localparam logic [15:0] ECP_PHASE_BLUE  = 16'd54460;
  localparam logic [15:0] ECP_PHASE_GREEN = 16'd59998;

  localparam logic [30:0] ECP_ONE_Q30 = 31'h4000_0000;

  // Taylor divisors of the Horner steps and their floor reciprocals in Q32.
  localparam logic [6:0] ECP_DIVS [4] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] ECP_RECIP [4] = '{
    32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),
    32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)
  };

  // Register stages inside one cosine lane.
  localparam int ECP_COS_LAT = 16;

endpackage

[rtl/core/ecp_cos.sv]
`timescale 1ns / 1ps

module ecp_cos (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] angle_i,
  output logic [7:0]  byte_o
);

  logic [30:0] theta_q [0:13];
  logic        neg_q   [0:14];
  logic [31:0] x2_q    [1:10];
  logic [31:0] hv_q    [4];
  logic [29:0] hq0_q   [4];
  logic [31:0] hvb_q   [4];
  logic [30:0] t_q     [4];
  logic [31:0] fin_q;
  logic [7:0]  byte_q;

  logic [14:0] reff;
  logic [46:0] theta_prod;
  logic [61:0] x2_prod;
  logic [61:0] fin_prod;
  logic [16:0] qs;
  logic [31:0] u_val;
  logic [31:0] w_val;
  logic [16:0] v_val;

  // Quadrants 0 and 2 use the complementary angle; 1 and 2 negate.
  always_comb begin
    reff       = angle_i[14] ? {1'b0, angle_i[13:0]} : 15'd16384 - {1'b0, angle_i[13:0]};
    theta_prod = 47'(reff) * 47'(ecp_pkg::ECP_PI_Q30);
    x2_prod    = 62'(theta_q[0]) * 62'(theta_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      theta_q[0] <= theta_prod[45:15];
      neg_q[0]   <= angle_i[15] ^ angle_i[14];
      x2_q[1]    <= x2_prod[61:30];
      for (int i = 1; i < 14; i++) begin
        theta_q[i] <= theta_q[i-1];
      end
      for (int i = 1; i < 15; i++) begin
        neg_q[i] <= neg_q[i-1];
      end
      for (int i = 2; i < 11; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
    end
  end

  // Each Horner step: multiply, reciprocal multiply, then one correction.
  for (genvar j = 0; j < 4; j++) begin : g_horner
    logic [30:0] t_in;
    logic [62:0] hprod;
    logic [61:0] rprod;
    logic [31:0] hrem;
    logic [29:0] hq;

    always_comb begin
      t_in  = (j == 0) ? ecp_pkg::ECP_ONE_Q30 : t_q[(j == 0) ? 0 : j-1];
      hprod = 63'(x2_q[1+3*j]) * 63'(t_in);
      rprod = 62'(hv_q[j]) * 62'(ecp_pkg::ECP_RECIP[j]);
      hrem  = hvb_q[j] - 32'(37'(hq0_q[j]) * 37'(ecp_pkg::ECP_DIVS[j]));
      hq    = (hrem >= 32'(ecp_pkg::ECP_DIVS[j])) ? hq0_q[j] + 30'd1 : hq0_q[j];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        hv_q[j]  <= hprod[61:30];
        hq0_q[j] <= rprod[61:32];
        hvb_q[j] <= hv_q[j];
        t_q[j]   <= ecp_pkg::ECP_ONE_Q30 - 31'(hq);
      end
    end
  end

  always_comb begin
    fin_prod = 62'(theta_q[13]) * 62'(t_q[3]);
    qs       = 17'((33'(fin_q) + 33'd32768) >> 16);
    u_val    = neg_q[14] ? 32'd16384 - 32'(qs) : 32'(qs) + 32'd16384;
    w_val    = (u_val << 8) - u_val;
    v_val    = w_val[31:15];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fin_q  <= fin_prod[61:30];
      byte_q <= (v_val > 17'd255) ? 8'hFF : v_val[7:0];
    end
  end

  assign byte_o = byte_q;

endmodule

[rtl/core/escape_count_cosine_palette.sv]
`timescale 1ns / 1ps
// Channel  | Handshake                  | Beat contents
// input    | in_valid_i / in_stall_o    | iteration_count_i
// output   | out_valid_o / out_stall_i  | blue_o, green_o, red_o, inside_set_o
// config   | cfg_we_i                   | cfg_wdata_i (max_iterations)
// One beat enters per cycle unless a valid output beat is stalled.
// The depth is set by the five-stage square root and the Horner steps of the cosine lanes.
// Reset clears the valid bits and loads max_iterations with 1000.
// A stalled valid output beat freezes the whole pipeline, so no beat is lost or repeated.

`include "escape_count_cosine_palette_macros.svh"

module escape_count_cosine_palette #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] iteration_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  blue_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic        inside_set_o
);

  localparam int CW    = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam int DEPTH = 8 + ecp_pkg::ECP_COS_LAT;

  typedef struct packed {
    logic [20:0] rem;
    logic [19:0] root;
    logic [15:0] rad;
  } sq_t;

  // Four digits of the square root per stage.
  function automatic sq_t sq_stage(input sq_t s);
    sq_t         o;
    logic [22:0] rw;
    logic [22:0] tr;
    o = s;
    for (int i = 0; i < 4; i++) begin
      rw    = {o.rem, o.rad[15:14]};
      tr    = {1'b0, o.root, 2'b01};
      o.rad = {o.rad[13:0], 2'b00};
      if (rw >= tr) begin
        o.rem  = 21'(rw - tr);
        o.root = {o.root[18:0], 1'b1};
      end else begin
        o.rem  = rw[20:0];
        o.root = {o.root[18:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic              en;
  logic [15:0]       max_q;
  logic [DEPTH-1:0]  vld_q;
  logic [DEPTH-1:0]  ins_q;
  logic [15:0]       count_q;
  sq_t               sq_q [1:5];
  logic [15:0]       ang_blue_q, ang_green_q, ang_red_q;
  logic [7:0]        blue_q, green_q, red_q;
  logic [15:0]       count_d;
  logic [50:0]       ang_prod;
  logic [15:0]       ang;
  logic [7:0]        byte_blue, byte_green, byte_red;

  assign en         = ~(vld_q[DEPTH-1] & out_stall_i);
  assign in_stall_o = ~en;
  assign count_d    = 16'(iteration_count_i[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'd1000;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (en) begin
        vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
      end
    end
  end

  always_comb begin
    ang_prod = 51'(sq_q[5].root) * 51'(ecp_pkg::ECP_INV_PI_Q32);
    ang      = ang_prod[43:28];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      count_q     <= count_d;
      ins_q       <= {ins_q[DEPTH-2:0], (count_d >= max_q)};
      sq_q[1]     <= sq_stage('{rem: '0, root: '0, rad: count_q});
      for (int k = 2; k <= 5; k++) begin
        sq_q[k] <= sq_stage(sq_q[k-1]);
      end
      ang_red_q   <= ang;
      ang_blue_q  <= ang + ecp_pkg::ECP_PHASE_BLUE;
      ang_green_q <= ang + ecp_pkg::ECP_PHASE_GREEN;
      blue_q      <= ins_q[DEPTH-2] ? 8'd0 : byte_blue;
      green_q     <= ins_q[DEPTH-2] ? 8'd0 : byte_green;
      red_q       <= ins_q[DEPTH-2] ? 8'd0 : byte_red;
    end
  end

  ecp_cos u_cos_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_blue_q),
    .byte_o  (byte_blue)
  );

  ecp_cos u_cos_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_green_q),
    .byte_o  (byte_green)
  );

  ecp_cos u_cos_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ang_red_q),
    .byte_o  (byte_red)
  );

  assign out_valid_o  = vld_q[DEPTH-1];
  assign inside_set_o = ins_q[DEPTH-1];
  assign blue_o       = blue_q;
  assign green_o      = green_q;
  assign red_o        = red_q;

  `ECP_ASSERT_SAME(a_stall_back, out_valid_o && out_stall_i, in_stall_o)
  `ECP_ASSERT_SAME(a_inside_black, out_valid_o && inside_set_o, (blue_o | green_o | red_o) == 8'd0)
  `ECP_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0])

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int PIPE_DEPTH = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1200;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       in_set;
  } pixel_color_t;

  // One row of the directed table: count, optional new maximum, and an
  // optional hand-typed color.
  typedef struct {
    logic [15:0]  count;
    bit           set_max;
    logic [15:0]  max_value;
    bit           typed;
    pixel_color_t color;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] iteration_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  blue_o;
  logic [7:0]  green_o;
  logic [7:0]  red_o;
  logic        inside_set_o;

  escape_count_cosine_palette #(.COUNT_WIDTH(16)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .iteration_count_i(iteration_count_i), .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i), .blue_o(blue_o), .green_o(green_o), .red_o(red_o),
    .inside_set_o(inside_set_o)
  );

  pixel_color_t expected_colors[$];
  logic [15:0]  max_iter_model;
  int           mismatch_count;
  int           colors_seen;
  int           inside_seen;
  longint       cycle_count;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Quarter-turn sine by a truncated Taylor series, Q14 result.
  function automatic int sine_quarter(int unsigned r);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] k [4];
    k = '{64'd72, 64'd42, 64'd20, 64'd6};
    theta = (64'(r) * 64'(ecp_pkg::ECP_PI_Q30)) >> 15;
    x2 = (theta * theta) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 4; i++) t = (64'd1 << 30) - ((x2 * t) >> 30) / k[i];
    return int'((((theta * t) >> 30) + (64'd1 << 15)) >> 16);
  endfunction

  function automatic logic [7:0] cos_to_byte(logic [15:0] p);
    int c;
    int unsigned v;
    case (p[15:14])
      2'd0: c = sine_quarter(16384 - p[13:0]);
      2'd1: c = -sine_quarter(p[13:0]);
      2'd2: c = -sine_quarter(16384 - p[13:0]);
      default: c = sine_quarter(p[13:0]);
    endcase
    v = (255 * unsigned'(c + 16384)) >> 15;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pixel_color_t color_of_count(logic [15:0] count);
    pixel_color_t c;
    logic [63:0] s_q12;
    logic [63:0] prod;
    logic [15:0] p;
    if (count >= max_iter_model) begin
      c = '{8'd0, 8'd0, 8'd0, 1'b1};
      return c;
    end
    s_q12 = int_sqrt(64'(count) << 24);
    prod = (s_q12 * 64'(ecp_pkg::ECP_INV_PI_Q32)) >> 28;
    p = prod[15:0];
    c.blue = cos_to_byte(p + ecp_pkg::ECP_PHASE_BLUE);
    c.green = cos_to_byte(p + ecp_pkg::ECP_PHASE_GREEN);
    c.red = cos_to_byte(p);
    c.in_set = 1'b0;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Sends one beat and holds it until accepted.
  task automatic send_count(logic [15:0] count, pixel_color_t typed_color, bit typed);
    pixel_color_t c;
    c = color_of_count(count);
    if (typed && c != typed_color) report_mismatch("directed table vs model", c, typed_color);
    expected_colors.push_back(typed ? typed_color : c);
    in_valid_i <= 1'b1;
    iteration_count_i <= count;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    iteration_count_i <= 16'($urandom);
  endtask

  task automatic drain_and_write(logic [15:0] value);
    drop_valid();
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_iter_model = value;
  endtask

  // Receiver stalls on its own pattern: quiet stretches and busy stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if ((cycle_count / 300) % 3 == 0) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 99) < 35);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d colors outstanding", expected_colors.size());
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected color beat", blue_o, -1);
      end else begin
        pixel_color_t want;
        want = expected_colors.pop_front();
        colors_seen++;
        if (inside_set_o) inside_seen++;
        if (blue_o !== want.blue) report_mismatch("blue", blue_o, want.blue);
        if (green_o !== want.green) report_mismatch("green", green_o, want.green);
        if (red_o !== want.red) report_mismatch("red", red_o, want.red);
        if (inside_set_o !== want.in_set) report_mismatch("inside_set", inside_set_o, want.in_set);
      end
    end
  end

  initial begin
    pixel_row_t rows[$];
    pixel_color_t black;
    logic [15:0] maxes[6];
    int sent;
    int burst;
    black = '{8'd0, 8'd0, 8'd0, 1'b1};
    maxes = '{16'd65535, 16'd1, 16'd0, 16'd37, 16'd40000, 16'd1000};
    mismatch_count = 0;
    colors_seen = 0;
    inside_seen = 0;
    cycle_count = 0;
    max_iter_model = 16'd1000;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    iteration_count_i = '0;

    // Colors typed in only where obvious; the rest use the predictor.
    rows.push_back('{16'd1000, 0, 16'd0, 1, black});
    rows.push_back('{16'd65535, 0, 16'd0, 1, black});
    rows.push_back('{16'd999, 0, 16'd0, 0, black});
    rows.push_back('{16'd0, 0, 16'd0, 0, black});
    rows.push_back('{16'd1, 0, 16'd0, 0, black});
    rows.push_back('{16'd2, 0, 16'd0, 0, black});
    rows.push_back('{16'd1001, 0, 16'd0, 1, black});
    rows.push_back('{16'd65535, 1, 16'd65535, 0, black});
    rows.push_back('{16'd65534, 0, 16'd0, 0, black});
    rows.push_back('{16'h5555, 0, 16'd0, 0, black});
    rows.push_back('{16'hAAAA, 0, 16'd0, 0, black});
    rows.push_back('{16'd0, 1, 16'd0, 1, black});
    rows.push_back('{16'd65535, 0, 16'd0, 1, black});
    rows.push_back('{16'd0, 1, 16'd1, 0, black});
    rows.push_back('{16'd1, 0, 16'd0, 1, black});
    rows.push_back('{16'd100, 1, 16'd101, 0, black});
    rows.push_back('{16'd101, 0, 16'd0, 1, black});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].set_max) drain_and_write(rows[i].max_value);
      send_count(rows[i].count, rows[i].color, rows[i].typed);
    end

    // Random phases, each under its own maximum.
    foreach (maxes[m]) begin
      drain_and_write(maxes[m]);
      sent = 0;
      while (sent < RANDOM_BEATS / 6) begin
        burst = $urandom_range(1, 40);
        if (burst > RANDOM_BEATS / 6 - sent) burst = RANDOM_BEATS / 6 - sent;
        for (int b = 0; b < burst; b++) begin
          logic [15:0] count;
          case ($urandom_range(0, 3))
            0: count = 16'($urandom);
            1: count = 16'($urandom_range(0, 300));
            2: count = max_iter_model + 16'($urandom_range(0, 2)) - 16'd1;
            default: count = 16'($urandom_range(0, 4000));
          endcase
          send_count(count, black, 0);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          drop_valid();
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end

    drop_valid();
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    $display("Checked %0d colors, %0d inside the set, over %0d maximum settings.",
             colors_seen, inside_seen, 6 + 4);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[escape_count_cosine_palette.f]
+incdir+rtl/core
rtl/core/ecp_pkg.sv
rtl/core/ecp_cos.sv
rtl/core/escape_count_cosine_palette.sv
tb/tb_top.sv
